[sv/month_calendar_grid_defines.svh]
// ============================================================================
// month_calendar_grid assertion macros
// Property wrappers for the calendar block; empty when SYNTH is defined.
// ============================================================================
`ifndef MONTH_CALENDAR_GRID_DEFINES_SVH
`define MONTH_CALENDAR_GRID_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define MCG_ASSERT_IMP(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed: cond -> prop");
// next-cycle implication
`define MCG_ASSERT_NXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed: cond => prop");
`else
`define MCG_ASSERT_IMP(label, clk, rst_n, cond, prop)
`define MCG_ASSERT_NXT(label, clk, rst_n, cond, prop)
`endif

`endif

[sv/mcg_pkg.sv]
// ============================================================================
// mcg_pkg
// Shared types, constants and calendar helper functions.
// ============================================================================
package mcg_pkg;

    localparam int unsigned MONTH_MAX = 12;
    localparam int unsigned YEAR_MAX  = 9999;
    localparam int unsigned WEEK_DAYS = 7;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic div;
        logic adj;
        logic sum;
        logic modw;
        logic wday;
        logic send_row;
        logic emit_err;
    } mcg_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic bad_input;
        logic row_last;
    } mcg_status_t;

    typedef logic [4:0] mcg_day_t;

    typedef struct packed {
        logic          valid;
        logic [2:0]    row_index;
        mcg_day_t [6:0] days;       // index 0 is Sunday
        logic [4:0]    month_length;
        logic [2:0]    start_weekday;
        logic          range_error;
        logic          last_row;
    } mcg_row_t;

    // floor(13*(m'+1)/5), with January and February as months 13 and 14
    function automatic logic [5:0] zeller_month_term(input logic [3:0] month);
        logic [5:0] term;
        unique case (month)
            4'd1:    term = 6'd36;
            4'd2:    term = 6'd39;
            4'd3:    term = 6'd10;
            4'd4:    term = 6'd13;
            4'd5:    term = 6'd15;
            4'd6:    term = 6'd18;
            4'd7:    term = 6'd20;
            4'd8:    term = 6'd23;
            4'd9:    term = 6'd26;
            4'd10:   term = 6'd28;
            4'd11:   term = 6'd31;
            4'd12:   term = 6'd33;
            default: term = 6'd0;
        endcase
        return term;
    endfunction

    function automatic logic [4:0] days_per_month(input logic [3:0] month, input logic leap);
        logic [4:0] d;
        unique case (month)
            4'd2:                      d = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
            default:                   d = 5'd31;
        endcase
        return d;
    endfunction

endpackage

[sv/mcg_datapath.sv]
// ============================================================================
// mcg_datapath
// Range check, Zeller weekday steps and calendar row generation.
// ============================================================================
module mcg_datapath
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [3:0]        month,
    input  logic [13:0]       year,
    input  mcg_pkg::mcg_cmd_t cmd,
    output mcg_pkg::mcg_status_t status,
    output mcg_pkg::mcg_row_t row
);

    logic [3:0]  month_reg;
    logic [13:0] year_reg;
    logic        bad_reg;
    logic [6:0]  cent_reg;       // year / 100
    logic [6:0]  k_reg;          // Zeller year of century
    logic [6:0]  j_reg;          // Zeller century
    logic [4:0]  days_reg;
    logic [9:0]  sum_reg;
    logic [6:0]  quot_reg;       // sum / 7
    logic [2:0]  first_reg;
    logic [2:0]  row_reg;

    logic          valid_reg;
    mcg_pkg::mcg_row_t out_reg;
    mcg_pkg::mcg_row_t out_next;

    logic        bad_in;
    logic [26:0] cent_prod;
    logic [13:0] rem_full;
    logic [6:0]  rem;
    logic        leap;
    logic [6:0]  k_next;
    logic [6:0]  j_next;
    logic [9:0]  sum_next;
    logic [22:0] quot_prod;
    logic [9:0]  h_full;
    logic [2:0]  h;
    logic [5:0]  row_base;
    logic [5:0]  span;
    logic [5:0]  first6;
    logic        last;
    mcg_pkg::mcg_day_t [6:0] cols;

    assign bad_in = (month == 4'd0) || (32'(month) > mcg_pkg::MONTH_MAX)
                 || (year == 14'd0) || (32'(year) > mcg_pkg::YEAR_MAX);

    // year / 100 by reciprocal, exact below 43699
    assign cent_prod = 27'(year_reg) * 27'd5243;

    assign rem_full = year_reg - 14'(cent_reg) * 14'd100;
    assign rem      = rem_full[6:0];
    assign leap     = ((year_reg[1:0] == 2'd0) && (rem != 7'd0))
                   || ((rem == 7'd0) && (cent_reg[1:0] == 2'd0));

    // January and February count as months of the year before
    always_comb
    begin
        k_next = rem;
        j_next = cent_reg;
        if (month_reg < 4'd3)
        begin
            if (rem == 7'd0)
            begin
                k_next = 7'd99;
                j_next = cent_reg - 7'd1;
            end
            else
            begin
                k_next = rem - 7'd1;
            end
        end
    end

    assign sum_next = 10'd1 + 10'(mcg_pkg::zeller_month_term(month_reg)) + 10'(k_reg)
                    + 10'(k_reg >> 2) + 10'(j_reg >> 2) + 10'(j_reg) * 10'd5;

    // sum / 7 by reciprocal, exact over the sum's range
    assign quot_prod = 23'(sum_reg) * 23'd4682;

    assign h_full = sum_reg - 10'(quot_reg) * 10'd7;
    assign h      = h_full[2:0];

    assign first6   = {3'b000, first_reg};
    assign row_base = 6'(row_reg) * 6'(mcg_pkg::WEEK_DAYS);
    assign span     = {1'b0, days_reg} + first6;
    assign last     = (row_base + 6'(mcg_pkg::WEEK_DAYS)) >= span;

    always_comb
    begin
        logic [5:0] pos;
        for (int c = 0; c < 7; c++)
        begin
            pos = row_base + 6'(c);
            if ((pos >= first6) && (pos < span))
            begin
                cols[c] = 5'(pos - first6 + 6'd1);
            end
            else
            begin
                cols[c] = 5'd0;
            end
        end
    end

    always_comb
    begin
        out_next = out_reg;
        out_next.valid = 1'b0;
        if (cmd.emit_err)
        begin
            out_next.row_index     = 3'd0;
            out_next.days          = '0;
            out_next.month_length  = 5'd0;
            out_next.start_weekday = 3'd0;
            out_next.range_error   = 1'b1;
            out_next.last_row      = 1'b1;
        end
        else if (cmd.send_row)
        begin
            out_next.row_index     = row_reg;
            out_next.days          = cols;
            out_next.month_length  = days_reg;
            out_next.start_weekday = first_reg;
            out_next.range_error   = 1'b0;
            out_next.last_row      = last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= cmd.send_row | cmd.emit_err;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (cmd.load)
        begin
            month_reg <= month;
            year_reg  <= year;
            bad_reg   <= bad_in;
            row_reg   <= 3'd0;
        end
        if (cmd.div)
        begin
            cent_reg <= cent_prod[25:19];
        end
        if (cmd.adj)
        begin
            k_reg    <= k_next;
            j_reg    <= j_next;
            days_reg <= mcg_pkg::days_per_month(month_reg, leap);
        end
        if (cmd.sum)
        begin
            sum_reg <= sum_next;
        end
        if (cmd.modw)
        begin
            quot_reg <= quot_prod[21:15];
        end
        if (cmd.wday)
        begin
            // Zeller counts from Saturday; shift to Sunday first
            first_reg <= (h == 3'd0) ? 3'd6 : h - 3'd1;
        end
        if (cmd.send_row)
        begin
            row_reg <= row_reg + 3'd1;
        end
    end

    assign status.bad_input = bad_reg;
    assign status.row_last  = last;

    always_comb
    begin
        row       = out_reg;
        row.valid = valid_reg;
    end

endmodule

[sv/mcg_ctrl.sv]
// ============================================================================
// mcg_ctrl
// Sequencer for request intake, weekday steps and row emission.
// ============================================================================
module mcg_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  mcg_pkg::mcg_status_t status,
    output mcg_pkg::mcg_cmd_t    cmd,
    output logic                 busy
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_ADJ  = 3'd2;
    localparam logic [2:0] ST_SUM  = 3'd3;
    localparam logic [2:0] ST_MOD  = 3'd4;
    localparam logic [2:0] ST_WDAY = 3'd5;
    localparam logic [2:0] ST_ROW  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                // drop straight to the error result on a bad request
                if (status.bad_input)
                begin
                    cmd.emit_err = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    cmd.div    = 1'b1;
                    state_next = ST_ADJ;
                end
            end
            ST_ADJ:
            begin
                cmd.adj    = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = ST_MOD;
            end
            ST_MOD:
            begin
                cmd.modw   = 1'b1;
                state_next = ST_WDAY;
            end
            ST_WDAY:
            begin
                cmd.wday   = 1'b1;
                state_next = ST_ROW;
            end
            ST_ROW:
            begin
                cmd.send_row = 1'b1;
                if (status.row_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

[sv/month_calendar_grid.sv]
// ============================================================================
// month_calendar_grid
// Gregorian month calendar, one seven-day row per result.
// ============================================================================
// A request (month, year) is taken at a clock edge with start high and busy
// low. The block checks the range, works out the leap year, month length and
// weekday of day one (Zeller's congruence), then sends the calendar rows.
// Each result is held for one cycle with row_valid high; the receiver cannot
// stall, so rows follow in consecutive cycles, last_row marking the final one.
// After the request edge the sequencer steps through load, divide by 100,
// adjust, sum, divide by 7 and weekday, then sends one row per cycle; a
// request that fails the range check gives its single error result straight
// after the load step instead. No new request is taken until the last row or
// the error result has been sent. busy is low again in the cycle the last row
// is shown.
// Reset (asynchronous, active low) returns the sequencer to idle and drops
// row_valid; no request in flight survives.
module month_calendar_grid
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  month,
    input  logic [13:0] year,
    output logic        row_valid,
    output logic [2:0]  row_index,
    output logic [4:0]  sunday_day,
    output logic [4:0]  monday_day,
    output logic [4:0]  tuesday_day,
    output logic [4:0]  wednesday_day,
    output logic [4:0]  thursday_day,
    output logic [4:0]  friday_day,
    output logic [4:0]  saturday_day,
    output logic [4:0]  month_length,
    output logic [2:0]  start_weekday,
    output logic        range_error,
    output logic        last_row
);

`include "month_calendar_grid_defines.svh"

    mcg_pkg::mcg_cmd_t    cmd;
    mcg_pkg::mcg_status_t status;
    mcg_pkg::mcg_row_t    row;

    mcg_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    mcg_datapath u_datapath
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .month  (month),
        .year   (year),
        .cmd    (cmd),
        .status (status),
        .row    (row)
    );

    assign row_valid     = row.valid;
    assign row_index     = row.row_index;
    assign sunday_day    = row.days[0];
    assign monday_day    = row.days[1];
    assign tuesday_day   = row.days[2];
    assign wednesday_day = row.days[3];
    assign thursday_day  = row.days[4];
    assign friday_day    = row.days[5];
    assign saturday_day  = row.days[6];
    assign month_length  = row.month_length;
    assign start_weekday = row.start_weekday;
    assign range_error   = row.range_error;
    assign last_row      = row.last_row;

    `MCG_ASSERT_IMP(a_err_single, clk, rst_n, row_valid && range_error, last_row)
    `MCG_ASSERT_NXT(a_rows_back_to_back, clk, rst_n, row_valid && !last_row, row_valid)
    `MCG_ASSERT_NXT(a_row_advance, clk, rst_n, row_valid && !last_row, row_index == 3'($past(row_index) + 3'd1))
    `MCG_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy)

endmodule

[dv/mcg_row_checker.sv]
// ============================================================================
// mcg_row_checker
// Watches the request and row channels of month_calendar_grid, builds the
// calendar rows each request should produce and compares them field by field.
// ============================================================================
module mcg_row_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [3:0]  month,
    input  logic [13:0] year,
    input  logic        row_valid,
    input  logic [2:0]  row_index,
    input  logic [4:0]  sunday_day,
    input  logic [4:0]  monday_day,
    input  logic [4:0]  tuesday_day,
    input  logic [4:0]  wednesday_day,
    input  logic [4:0]  thursday_day,
    input  logic [4:0]  friday_day,
    input  logic [4:0]  saturday_day,
    input  logic [4:0]  month_length,
    input  logic [2:0]  start_weekday,
    input  logic        range_error,
    input  logic        last_row,
    output int          mismatch_count,
    output int          rows_pending
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [2:0]        row_index;
        mcg_pkg::mcg_day_t days [7];    // Sunday first
        logic [4:0]        month_length;
        logic [2:0]        start_weekday;
        logic              range_error;
        logic              last_row;
    } cal_row_t;

    cal_row_t expected_rows [$];

    task automatic report_mismatch(input string msg);
        $display("%0t mcg_row_checker: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic bit gregorian_leap(input int y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    // Queue the rows that one request is due to produce.
    function automatic void build_month_rows(input logic [3:0] m, input logic [13:0] y);
        cal_row_t row;
        int       mon;
        int       yr;
        int       len;
        int       first;
        int       zm;
        int       zy;
        int       cent;
        int       yoc;
        int       h;
        int       slot;
        int       base;
        int       rows;
        mon  = m;
        yr   = y;
        rows = 0;
        row.row_index     = '0;
        row.month_length  = '0;
        row.start_weekday = '0;
        row.range_error   = 1'b0;
        row.last_row      = 1'b0;
        for (int c = 0; c < 7; c++)
            row.days[c] = '0;
        if (mon < 1 || mon > mcg_pkg::MONTH_MAX || yr < 1 || yr > mcg_pkg::YEAR_MAX)
        begin
            row.range_error = 1'b1;
            row.last_row    = 1'b1;
            expected_rows.push_back(row);
            return;
        end
        unique case (mon)
            2:           len = gregorian_leap(yr) ? 29 : 28;
            4, 6, 9, 11: len = 30;
            default:     len = 31;
        endcase
        // Zeller: January and February count as months 13 and 14 of the prior year
        zm = mon;
        zy = yr;
        if (zm < 3)
        begin
            zm += 12;
            zy -= 1;
        end
        yoc   = zy % 100;
        cent  = zy / 100;
        h     = (1 + (13 * (zm + 1)) / 5 + yoc + yoc / 4 + cent / 4 + 5 * cent) % 7;
        first = (h + 6) % 7;
        for (base = 0; base < len + first && rows < 6; base += 7)
        begin
            row.row_index = rows[2:0];
            for (int c = 0; c < 7; c++)
            begin
                slot = base + c;
                row.days[c] = (slot >= first && slot < first + len) ? 5'(slot - first + 1) : 5'd0;
            end
            row.month_length  = len[4:0];
            row.start_weekday = first[2:0];
            row.range_error   = 1'b0;
            row.last_row      = (base + 7 >= len + first);
            expected_rows.push_back(row);
            rows++;
        end
    endfunction

    always @(posedge clk)
    begin : watch
        cal_row_t    want;
        logic [4:0]  got_days [7];
        string       day_names [7];
        day_names = '{"sunday_day", "monday_day", "tuesday_day", "wednesday_day",
                      "thursday_day", "friday_day", "saturday_day"};
        got_days  = '{sunday_day, monday_day, tuesday_day, wednesday_day,
                      thursday_day, friday_day, saturday_day};
        if (rst_n)
        begin
            // check the row on the wires before queueing a request taken at this edge
            if (row_valid === 1'b1)
            begin
                if (expected_rows.size() == 0)
                begin
                    report_mismatch($sformatf("row %0d arrived with no row expected",
                                              row_index));
                end
                else
                begin
                    want = expected_rows.pop_front();
                    if (row_index !== want.row_index)
                        report_mismatch($sformatf("row_index got %0d expected %0d",
                                                  row_index, want.row_index));
                    for (int c = 0; c < 7; c++)
                        if (got_days[c] !== want.days[c])
                            report_mismatch($sformatf("row %0d %s got %0d expected %0d",
                                                      want.row_index, day_names[c],
                                                      got_days[c], want.days[c]));
                    if (month_length !== want.month_length)
                        report_mismatch($sformatf("row %0d month_length got %0d expected %0d",
                                                  want.row_index, month_length,
                                                  want.month_length));
                    if (start_weekday !== want.start_weekday)
                        report_mismatch($sformatf("row %0d start_weekday got %0d expected %0d",
                                                  want.row_index, start_weekday,
                                                  want.start_weekday));
                    if (range_error !== want.range_error)
                        report_mismatch($sformatf("row %0d range_error got %0b expected %0b",
                                                  want.row_index, range_error,
                                                  want.range_error));
                    if (last_row !== want.last_row)
                        report_mismatch($sformatf("row %0d last_row got %0b expected %0b",
                                                  want.row_index, last_row, want.last_row));
                end
            end
            if (start === 1'b1 && busy === 1'b0)
                build_month_rows(month, year);
        end
        rows_pending <= expected_rows.size();
    end

endmodule

[dv/tb_month_calendar_grid.sv]
// ============================================================================
// tb_month_calendar_grid
// Drives month/year requests into month_calendar_grid: a directed set of
// range edges, leap rules and row counts, then random requests under three
// sender idle profiles. Checking is done by mcg_row_checker.
// ============================================================================
module tb_month_calendar_grid;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 100000;
    localparam int PHASE_ITEMS  = 61;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [3:0]  month;
    logic [13:0] year;
    logic        row_valid;
    logic [2:0]  row_index;
    logic [4:0]  sunday_day;
    logic [4:0]  monday_day;
    logic [4:0]  tuesday_day;
    logic [4:0]  wednesday_day;
    logic [4:0]  thursday_day;
    logic [4:0]  friday_day;
    logic [4:0]  saturday_day;
    logic [4:0]  month_length;
    logic [2:0]  start_weekday;
    logic        range_error;
    logic        last_row;

    int          mismatch_count;
    int          rows_pending;
    int          idle_pct;
    int          cycle_count;

    month_calendar_grid i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .month         (month),
        .year          (year),
        .row_valid     (row_valid),
        .row_index     (row_index),
        .sunday_day    (sunday_day),
        .monday_day    (monday_day),
        .tuesday_day   (tuesday_day),
        .wednesday_day (wednesday_day),
        .thursday_day  (thursday_day),
        .friday_day    (friday_day),
        .saturday_day  (saturday_day),
        .month_length  (month_length),
        .start_weekday (start_weekday),
        .range_error   (range_error),
        .last_row      (last_row)
    );

    mcg_row_checker i_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .month          (month),
        .year           (year),
        .row_valid      (row_valid),
        .row_index      (row_index),
        .sunday_day     (sunday_day),
        .monday_day     (monday_day),
        .tuesday_day    (tuesday_day),
        .wednesday_day  (wednesday_day),
        .thursday_day   (thursday_day),
        .friday_day     (friday_day),
        .saturday_day   (saturday_day),
        .month_length   (month_length),
        .start_weekday  (start_weekday),
        .range_error    (range_error),
        .last_row       (last_row),
        .mismatch_count (mismatch_count),
        .rows_pending   (rows_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_month_calendar_grid: done, errors");
            $finish;
        end
    end

    // Idle a random number of cycles, then hold the request until it is taken.
    task automatic send_request(input logic [3:0] m, input logic [13:0] y);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct && gap < 40)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        month <= m;
        year  <= y;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Drop start and wait until every expected row has come out.
    task automatic drain_rows();
        start <= 1'b0;
        @(posedge clk);
        while (rows_pending != 0)
            @(posedge clk);
    endtask

    task automatic send_random_request();
        int          sel;
        int          bad;
        logic [3:0]  m;
        logic [13:0] y;
        sel = $urandom_range(99);
        if (sel < 15)
        begin
            // February of a century or leap-candidate year
            m = 4'd2;
            y = ($urandom_range(1)) ? 14'(100 * $urandom_range(99, 1))
                                    : 14'(4 * $urandom_range(2499, 1));
        end
        else if (sel < 80)
        begin
            m = 4'($urandom_range(12, 1));
            y = 14'($urandom_range(9999, 1));
        end
        else if (sel < 88)
        begin
            bad = $urandom_range(3);
            m = (bad == 0) ? 4'd0 : 4'(12 + bad);
            y = 14'($urandom_range(9999, 1));
        end
        else if (sel < 94)
        begin
            m = 4'($urandom_range(12, 1));
            y = ($urandom_range(1)) ? 14'd0 : 14'($urandom_range(16383, 10000));
        end
        else
        begin
            m = 4'($urandom);
            y = 14'($urandom);
        end
        send_request(m, y);
    endtask

    initial
    begin
        rst_n    = 1'b0;
        start    = 1'b0;
        month    = '0;
        year     = '0;
        idle_pct = 38;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // out of range month, out of range year, both
        send_request(4'd0,  14'd2024);
        send_request(4'd13, 14'd2024);
        send_request(4'd15, 14'd2024);
        send_request(4'd6,  14'd0);
        send_request(4'd6,  14'd10000);
        send_request(4'd6,  14'd16383);
        send_request(4'd15, 14'd16383);
        send_request(4'd0,  14'd0);
        // extremes of the valid range
        send_request(4'd1,  14'd1);
        send_request(4'd12, 14'd9999);
        // leap rules: divisible by 400, by 100 only, plain
        send_request(4'd2,  14'd2000);
        send_request(4'd2,  14'd1900);
        send_request(4'd2,  14'd2023);
        // four rows (Feb starting Sunday) and six rows (31 days from Saturday)
        send_request(4'd2,  14'd2015);
        send_request(4'd1,  14'd2022);
        for (int m = 1; m <= 12; m++)
            send_request(4'(m), 14'd2024);

        // hold off until the block has emptied out
        drain_rows();

        for (int phase = 0; phase < 3; phase++)
        begin
            unique case (phase)
                0:       idle_pct = 38;
                1:       idle_pct = 54;
                default: idle_pct = 0;
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_random_request();
            drain_rows();
        end

        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && rows_pending == 0)
            $display("tb_month_calendar_grid: done, clean");
        else
            $display("tb_month_calendar_grid: done, errors");
        $finish;
    end

endmodule

[sim.f]
+incdir+sv
sv/mcg_pkg.sv
sv/mcg_datapath.sv
sv/mcg_ctrl.sv
sv/month_calendar_grid.sv
dv/mcg_row_checker.sv
dv/tb_month_calendar_grid.sv
